// ===== rtl/core/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types, constants and controller/datapath interface structs for the
// sha-1 hash engine
// ----------------------------------------------------------------------------
package sha1_pkg;

   // round constants
   localparam logic [31:0] K_R0 = 32'h5A827999;
   localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3 = 32'hCA62C1D6;

   // initial chaining value
   localparam int unsigned DIGEST_WORDS = 5;
   localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // block geometry
   localparam int unsigned WIN_WORDS  = 16;
   localparam logic [5:0]  BLOCK_LAST = 6'd63;
   localparam logic [5:0]  LEN_POS    = 6'd56;
   localparam logic [7:0]  PAD_MARK   = 8'h80;
   localparam logic [6:0]  ROUND_LAST = 7'd79;

   // input item codes
   localparam logic REQ_ABSORB = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   // source of the byte written into the block buffer
   typedef enum logic [1:0] {
      BYTE_DATA,
      BYTE_MARK,
      BYTE_ZERO,
      BYTE_LEN
   } byte_src_type;

   typedef struct packed {
      logic         byte_we;
      byte_src_type byte_src;
      logic         latch_len;
      logic         rnd_start;
      logic         rnd_step;
      logic         chain_add;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic [5:0] pos;
      logic       round_last;
      logic       out_busy;
   } status_type;

endpackage

// ===== rtl/core/sha1_hash_engine.sv =====
// Flow: an absorbed byte is written to the block buffer; the 64th byte of a
//   block starts 80 compression rounds (one per cycle) and the chaining add.
// Input is held off while a block is compressed and chained, as the single
//   round unit serves every round of every block.
// Finish: one pad or length byte per cycle, then one or two compressions;
//   the first digest word is shown in the cycle after the output stage is free.
// Reset: synchronous, active high; chaining words and bit count to initial.
// ----------------------------------------------------------------------------
// sha1_hash_engine
// sha-1 hash engine top level: byte-wide absorb, padding and 5-word digest
// ----------------------------------------------------------------------------
module sha1_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_word_last
);
   import sha1_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   sha1_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   sha1_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_last   (rsp_word_last)
   );

endmodule

// ===== rtl/core/sha1_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1_ctrl
// sequencer for byte absorb, padding, the 80 compression rounds and digest
// hand-off to the output stage
// ----------------------------------------------------------------------------
module sha1_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_type,
   output logic                 req_stall,
   input  sha1_pkg::status_type status,
   output sha1_pkg::cmd_type    cmd
);
   import sha1_pkg::*;

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;           // finishing a message
   logic      len_ok_ff, len_ok_in;     // length may go into this block
   logic      last_blk_ff, last_blk_in; // running block holds the length

   logic req_accept;
   logic in_len_zone;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign in_len_zone = (status.pos >= LEN_POS);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fin_ff      <= 1'b0;
         len_ok_ff   <= 1'b0;
         last_blk_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fin_ff      <= fin_in;
         len_ok_ff   <= len_ok_in;
         last_blk_ff <= last_blk_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in    = state_ff;
      fin_in      = fin_ff;
      len_ok_in   = len_ok_ff;
      last_blk_in = last_blk_ff;
      cmd         = '0;
      cmd.byte_src = BYTE_DATA;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.byte_we = 1'b1;
               if (req_type == REQ_FINISH) begin
                  cmd.byte_src  = BYTE_MARK;
                  cmd.latch_len = 1'b1;
                  fin_in        = 1'b1;
                  len_ok_in     = !in_len_zone;
                  last_blk_in   = 1'b0;
                  state_in      = ST_PAD;
               end
               if (status.pos == BLOCK_LAST) begin
                  cmd.rnd_start = 1'b1;
                  state_in      = ST_ROUND;
               end
            end
         end

         // one pad or length byte per cycle
         ST_PAD: begin
            cmd.byte_we  = 1'b1;
            cmd.byte_src = (len_ok_ff && in_len_zone) ? BYTE_LEN : BYTE_ZERO;
            if (status.pos == BLOCK_LAST) begin
               cmd.rnd_start = 1'b1;
               last_blk_in   = len_ok_ff;
               state_in      = ST_ROUND;
            end
         end

         ST_ROUND: begin
            cmd.rnd_step = 1'b1;
            if (status.round_last) begin
               state_in = ST_ADD;
            end
         end

         ST_ADD: begin
            cmd.chain_add = 1'b1;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (last_blk_ff) begin
               state_in = ST_OUT;
            end else begin
               len_ok_in = 1'b1;
               state_in  = ST_PAD;
            end
         end

         // wait for the output stage to drain the previous digest
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               fin_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/sha1_dp.sv =====
// ----------------------------------------------------------------------------
// sha1_dp
// block buffer / schedule window, round logic, chaining words, bit count and
// the digest output stage
// ----------------------------------------------------------------------------
module sha1_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_data_byte,
   input  sha1_pkg::cmd_type    cmd,
   output sha1_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_digest_word,
   output logic                 rsp_word_last
);
   import sha1_pkg::*;

   // message words, rotated one place per round
   logic [31:0] win_ff   [WIN_WORDS];
   logic [31:0] win_in   [WIN_WORDS];
   logic [31:0] vars_ff  [DIGEST_WORDS];
   logic [31:0] vars_in  [DIGEST_WORDS];
   logic [31:0] chain_ff [DIGEST_WORDS];
   logic [31:0] chain_in [DIGEST_WORDS];
   logic [31:0] out_ff   [DIGEST_WORDS];
   logic [31:0] out_in   [DIGEST_WORDS];
   logic [2:0]  out_cnt_ff, out_cnt_in;
   logic [6:0]  round_ff, round_in;
   logic [63:0] bit_len_ff, bit_len_in;
   logic [63:0] len_latch_ff, len_latch_in;

   logic [5:0]  pos;
   logic [7:0]  wr_byte;
   logic [7:0]  len_byte;
   logic [4:0]  lane_sh;
   logic [31:0] lane_mask;
   logic [31:0] w_cur;
   logic [31:0] w_mix;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] t_val;
   logic        rsp_accept;

   assign pos         = bit_len_ff[8:3];
   assign rsp_accept  = rsp_valid && !rsp_stall;
   assign len_byte    = 8'(len_latch_ff >> {~pos[2:0], 3'b000});
   assign lane_sh     = {~pos[1:0], 3'b000};
   assign lane_mask   = 32'hFF << lane_sh;

   assign status.pos        = pos;
   assign status.round_last = (round_ff == ROUND_LAST);
   assign status.out_busy   = (out_cnt_ff != 3'd0);

   assign rsp_valid       = (out_cnt_ff != 3'd0);
   assign rsp_digest_word = out_ff[0];
   assign rsp_word_last   = (out_cnt_ff == 3'd1);

   // byte to buffer
   always_comb begin
      case (cmd.byte_src)
         BYTE_DATA: wr_byte = req_data_byte;
         BYTE_MARK: wr_byte = PAD_MARK;
         BYTE_ZERO: wr_byte = 8'h00;
         BYTE_LEN:  wr_byte = len_byte;
         default:   wr_byte = 8'h00;
      endcase
   end

   // schedule word for this round
   always_comb begin
      w_mix = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      if (round_ff < 7'd16) begin
         w_cur = win_ff[0];
      end else begin
         w_cur = {w_mix[30:0], w_mix[31]};
      end
   end

   // round function and constant
   always_comb begin
      if (round_ff inside {[7'd0:7'd19]}) begin
         f_val = (vars_ff[1] & vars_ff[2]) | (~vars_ff[1] & vars_ff[3]);
         k_val = K_R0;
      end else if (round_ff inside {[7'd20:7'd39]}) begin
         f_val = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
         k_val = K_R1;
      end else if (round_ff inside {[7'd40:7'd59]}) begin
         f_val = (vars_ff[1] & vars_ff[2]) | (vars_ff[1] & vars_ff[3]) |
                 (vars_ff[2] & vars_ff[3]);
         k_val = K_R2;
      end else begin
         f_val = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
         k_val = K_R3;
      end
      t_val = f_val + k_val + {vars_ff[0][26:0], vars_ff[0][31:27]} + vars_ff[4] + w_cur;
   end

   // window: byte writes while absorbing, rotation while compressing
   always_comb begin
      for (int i = 0; i < WIN_WORDS; i++) begin
         win_in[i] = win_ff[i];
         if (cmd.byte_we && (pos[5:2] == 4'(i))) begin
            win_in[i] = (win_ff[i] & ~lane_mask) | (32'(wr_byte) << lane_sh);
         end
      end
      if (cmd.rnd_step) begin
         for (int i = 0; i < WIN_WORDS - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[WIN_WORDS - 1] = w_cur;
      end
   end

   // working variables and round count
   always_comb begin
      vars_in  = vars_ff;
      round_in = round_ff;
      if (cmd.rnd_start) begin
         vars_in  = chain_ff;
         round_in = 7'd0;
      end else if (cmd.rnd_step) begin
         vars_in[0] = t_val;
         vars_in[1] = vars_ff[0];
         vars_in[2] = {vars_ff[1][1:0], vars_ff[1][31:2]};
         vars_in[3] = vars_ff[2];
         vars_in[4] = vars_ff[3];
         round_in   = round_ff + 7'd1;
      end
   end

   // chaining words, bit count and length capture
   always_comb begin
      chain_in     = chain_ff;
      bit_len_in   = bit_len_ff;
      len_latch_in = len_latch_ff;
      if (cmd.chain_add) begin
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
      if (cmd.byte_we) begin
         bit_len_in = bit_len_ff + 64'd8;
      end
      if (cmd.latch_len) begin
         len_latch_in = bit_len_ff;
      end
      if (cmd.out_load) begin
         chain_in   = H_INIT;
         bit_len_in = 64'd0;
      end
   end

   // digest output stage
   always_comb begin
      out_in     = out_ff;
      out_cnt_in = out_cnt_ff;
      if (cmd.out_load) begin
         out_in     = chain_ff;
         out_cnt_in = 3'(DIGEST_WORDS);
      end else if (rsp_accept) begin
         for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
            out_in[i] = out_ff[i + 1];
         end
         out_cnt_in = out_cnt_ff - 3'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff   <= H_INIT;
         bit_len_ff <= 64'd0;
         out_cnt_ff <= 3'd0;
         round_ff   <= 7'd0;
      end else begin
         chain_ff   <= chain_in;
         bit_len_ff <= bit_len_in;
         out_cnt_ff <= out_cnt_in;
         round_ff   <= round_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      win_ff       <= win_in;
      vars_ff      <= vars_in;
      out_ff       <= out_in;
      len_latch_ff <= len_latch_in;
   end

endmodule

// ===== rtl/core/sha1_checker.sv =====
// ----------------------------------------------------------------------------
// sha1_checker
// port-level checks on the sha-1 hash engine, bound to the top level
// ----------------------------------------------------------------------------
module sha1_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_type,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic        rsp_word_last
);
   import sha1_pkg::*;

   // no word shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digest_word) &&
                                  $stable(rsp_word_last))
      else $error("stalled result word changed");

   // digest ends cleanly after its last word
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_word_last |=> !rsp_valid)
      else $error("result word follows last digest word at once");

   // finish goes into padding or a compression, so input is held off next cycle
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == REQ_FINISH) |=> req_stall)
      else $error("input taken right after a finish word");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_last   (rsp_word_last)
);
